[design/i2c_register_transfer_sequencer_assert.svh]
// ----------------------------------------------------------------------------
// I2C register transfer sequencer assertion macros
// Shared concurrent assertion forms, reset-qualified on an active-low reset.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_TRANSFER_SEQUENCER_ASSERT_SVH
`define I2C_REGISTER_TRANSFER_SEQUENCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2C_RTS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2C_RTS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/i2c_rts_pkg.sv]
// ----------------------------------------------------------------------------
// I2C register transfer sequencer package
// Types, codes and constants shared by the sequencer modules.
// ----------------------------------------------------------------------------
package i2c_rts_pkg;

    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned WORD_W         = 16;
    localparam int unsigned IRQ_W          = 3;
    localparam int unsigned IRQ_TX_EMPTY   = 0;
    localparam int unsigned IRQ_RX_FULL    = 1;
    localparam int unsigned IRQ_ABORT      = 2;
    localparam logic [1:0]  WR_TOTAL_BYTES = 2'd3;
    localparam logic [1:0]  RD_TOTAL_BYTES = 2'd2;

    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 40;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_EVENT = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        WR_IDLE    = 2'd0,
        WR_SENDING = 2'd1,
        WR_DONE    = 2'd2
    } wr_phase_t;

    typedef enum logic [1:0] {
        RD_IDLE      = 2'd0,
        RD_POINTER   = 2'd1,
        RD_RECEIVING = 2'd2,
        RD_DONE      = 2'd3
    } rd_phase_t;

    typedef struct packed {
        logic [1:0]        action;
        logic [BYTE_W-1:0] reg_pointer;
        logic [WORD_W-1:0] write_value;
        logic              abort_seen;
        logic              tx_empty;
        logic              rx_ready;
        logic [BYTE_W-1:0] rx_byte;
    } item_t;

    typedef struct packed {
        wr_phase_t         wr_phase;
        logic [1:0]        wr_byte_index;
        logic [WORD_W-1:0] wr_word;
        rd_phase_t         rd_phase;
        logic [1:0]        rd_byte_count;
        logic [WORD_W-1:0] rd_word;
        logic              rd_ready;
        logic              error_flag;
        logic [IRQ_W-1:0]  irq_enables;
    } state_t;

    typedef struct packed {
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
    } push_t;

endpackage

[design/i2c_register_transfer_sequencer.sv]
// ----------------------------------------------------------------------------
// I2C register transfer sequencer
// Sequences pointer, data and receive bytes of 16-bit device register access.
// ----------------------------------------------------------------------------
// An accepted word passes through the input register and then the result
// register before its result word shows on the master side.
// Throughput: one word per cycle; the input register and the result register
// both advance every cycle when the master side takes its word.
// Reset: synchronous, active low; the sequencer state, both valid flags and
// the interrupt-enable status are restored, the held write word is not.
// ----------------------------------------------------------------------------
module i2c_register_transfer_sequencer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata: reg_pointer[7:0], write_value[23:8], abort_seen[24], tx_empty[25],
    //        rx_ready[26], rx_byte[34:27], zero pad[39:35]
    input  logic [i2c_rts_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: action[1:0]
    input  logic [i2c_rts_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata: tx_valid[0], tx_byte[8:1], read_value[24:9], read_valid[25],
    //        write_phase[27:26], read_phase[29:28], bus_error[30],
    //        tx_empty_irq_on[31], rx_full_irq_on[32], abort_irq_on[33],
    //        zero pad[39:34]
    output logic [i2c_rts_pkg::M_TDATA_W-1:0] m_tdata
);
    import i2c_rts_pkg::*;

    // Input register stage. It holds one accepted word until the step logic
    // folds it into the sequencer state.
    logic   in_valid_reg;
    logic   in_valid_next;
    item_t  in_item_reg;
    item_t  in_item;

    // Sequencer state, split so that the held write word carries no reset.
    state_t state_reg;
    state_t state_next;
    logic [WORD_W-1:0] wr_word_reg;

    // Result register stage.
    logic   out_valid_reg;
    logic   out_valid_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;

    state_t cur_state;
    push_t  push;
    logic   advance;

    // The registered word moves into the result register whenever that
    // register is empty or being emptied in the same cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign in_item.action      = s_tuser[1:0];
    assign in_item.reg_pointer = s_tdata[7:0];
    assign in_item.write_value = s_tdata[23:8];
    assign in_item.abort_seen  = s_tdata[24];
    assign in_item.tx_empty    = s_tdata[25];
    assign in_item.rx_ready    = s_tdata[26];
    assign in_item.rx_byte     = s_tdata[34:27];

    always_comb begin
        cur_state         = state_reg;
        cur_state.wr_word = wr_word_reg;
    end

    i2c_rts_step u_step (
        .item (in_item_reg),
        .cur  (cur_state),
        .nxt  (state_next),
        .push (push)
    );

    // The result word reports the push of this item and the state after it.
    assign out_data_next = {
        {(M_TDATA_W - 34){1'b0}},
        state_next.irq_enables[IRQ_ABORT],
        state_next.irq_enables[IRQ_RX_FULL],
        state_next.irq_enables[IRQ_TX_EMPTY],
        state_next.error_flag,
        state_next.rd_phase,
        state_next.wr_phase,
        state_next.rd_ready,
        state_next.rd_word,
        push.tx_byte,
        push.tx_valid
    };

    assign in_valid_next  = (s_tvalid && s_tready) || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg            <= 1'b0;
            out_valid_reg           <= 1'b0;
            state_reg.wr_phase      <= WR_IDLE;
            state_reg.wr_byte_index <= 2'd0;
            state_reg.wr_word       <= '0;
            state_reg.rd_phase      <= RD_IDLE;
            state_reg.rd_byte_count <= 2'd0;
            state_reg.rd_word       <= '0;
            state_reg.rd_ready      <= 1'b0;
            state_reg.error_flag    <= 1'b0;
            state_reg.irq_enables   <= '1;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= in_item;
        end
        if (advance) begin
            wr_word_reg  <= state_next.wr_word;
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `include "i2c_register_transfer_sequencer_assert.svh"

    // The abort flag is sticky until reset.
    `I2C_RTS_ASSERT_NEXT(a_error_sticky, aclk, aresetn, state_reg.error_flag, state_reg.error_flag, "bus error flag cleared without reset")
    // A finished read is always in its done phase.
    `I2C_RTS_ASSERT_SAME(a_ready_done, aclk, aresetn, state_reg.rd_ready, state_reg.rd_phase == RD_DONE, "read ready outside done phase")
    // A finished write has sent all three bytes.
    `I2C_RTS_ASSERT_SAME(a_write_count, aclk, aresetn, state_reg.wr_phase == WR_DONE, state_reg.wr_byte_index == WR_TOTAL_BYTES, "write done before all bytes sent")
    // An empty result register never blocks the input side.
    `I2C_RTS_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !out_valid_reg, s_tready, "input stalled with empty result register")

endmodule

[design/i2c_rts_step.sv]
// ----------------------------------------------------------------------------
// I2C register transfer sequencer step logic
// Combinational next-state and transmit-push logic for one item.
// ----------------------------------------------------------------------------
module i2c_rts_step (
    input  i2c_rts_pkg::item_t  item,
    input  i2c_rts_pkg::state_t cur,
    output i2c_rts_pkg::state_t nxt,
    output i2c_rts_pkg::push_t  push
);
    import i2c_rts_pkg::*;

    logic [1:0] wr_idx_inc;
    logic [1:0] rd_cnt_inc;

    assign wr_idx_inc = (cur.wr_byte_index < WR_TOTAL_BYTES) ? cur.wr_byte_index + 2'd1
                                                             : cur.wr_byte_index;
    assign rd_cnt_inc = (cur.rd_byte_count < RD_TOTAL_BYTES) ? cur.rd_byte_count + 2'd1
                                                             : cur.rd_byte_count;

    // Next state.
    always_comb begin
        nxt = cur;
        unique case (item.action)
            ACT_WRITE: begin
                nxt.wr_phase                = WR_SENDING;
                nxt.wr_word                 = item.write_value;
                nxt.wr_byte_index           = 2'd1;
                nxt.irq_enables[IRQ_TX_EMPTY] = 1'b1;
                nxt.irq_enables[IRQ_ABORT]  = 1'b1;
            end
            ACT_READ: begin
                nxt.rd_phase      = RD_POINTER;
                nxt.rd_byte_count = 2'd0;
                nxt.rd_ready      = 1'b0;
                nxt.irq_enables   = '1;
            end
            ACT_EVENT: begin
                if (item.abort_seen) begin
                    nxt.error_flag = 1'b1;
                end else begin
                    if (item.tx_empty) begin
                        if (cur.wr_phase == WR_SENDING) begin
                            nxt.wr_byte_index = wr_idx_inc;
                            if (wr_idx_inc >= WR_TOTAL_BYTES) begin
                                nxt.irq_enables[IRQ_TX_EMPTY] = 1'b0;
                                nxt.wr_phase                  = WR_DONE;
                            end
                        end
                        if (cur.rd_phase == RD_POINTER) begin
                            nxt.rd_phase                  = RD_RECEIVING;
                            nxt.irq_enables[IRQ_TX_EMPTY] = 1'b0;
                        end
                    end
                    if (item.rx_ready) begin
                        nxt.rd_word       = {cur.rd_word[BYTE_W-1:0], item.rx_byte};
                        nxt.rd_byte_count = rd_cnt_inc;
                        if (rd_cnt_inc >= RD_TOTAL_BYTES) begin
                            nxt.irq_enables[IRQ_RX_FULL] = 1'b0;
                            nxt.rd_ready                 = 1'b1;
                            nxt.rd_phase                 = RD_DONE;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Transmit push: pointer on a start item, data bytes on transmit-empty while a write is sending.
    always_comb begin
        push = '0;
        unique case (item.action)
            ACT_WRITE, ACT_READ: begin
                push.tx_valid = 1'b1;
                push.tx_byte  = item.reg_pointer;
            end
            ACT_EVENT: begin
                if (!item.abort_seen && item.tx_empty && cur.wr_phase == WR_SENDING) begin
                    push.tx_valid = 1'b1;
                    push.tx_byte  = (cur.wr_byte_index <= 2'd1) ? cur.wr_word[WORD_W-1:BYTE_W]
                                                                : cur.wr_word[BYTE_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

endmodule
